@@ design/vfc_pkg.sv @@
`default_nettype none

package vfc_pkg;

    // Build-time defaults for the scaling constants
    localparam int unsigned FULL_SCALE_DEF = 65535;
    localparam int unsigned SPAN_RATIO_DEF = 8;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned VALUE_W = 29;

    // APB register map: register i at byte address 4*i
    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_ENABLE     = 1'b0;
    localparam logic        REG_MAX_OUTPUT = 1'b1;

    localparam logic               ENABLE_RST     = 1'b1;
    localparam logic [VALUE_W-1:0] MAX_OUTPUT_RST = VALUE_W'(65535);

    typedef struct packed {
        logic [COUNT_W-1:0] pulse_count;
        logic [COUNT_W-1:0] window_ticks;
        logic               pin_high;
    } vfc_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] converted_value;
        logic               saturated;
    } vfc_out_t;

    typedef struct packed {
        logic               enable;
        logic [VALUE_W-1:0] max_output;
    } vfc_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vfc_div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } vfc_state_t;

endpackage

`default_nettype wire

@@ design/vf_adc_window_converter.sv @@
// Channel  | Signals                          | Transfer when
// ---------+----------------------------------+------------------------------
// src      | src_valid, src_stall, src_data   | src_valid && !src_stall
// res      | res_valid, res_stall, res_data   | res_valid && !res_stall
// cfg      | APB psel/penable/pwrite/paddr... | psel && penable && pwrite
//
// Paths: special cases (no pulses, at/below baseline, zero window) go from
// transfer through ST_DONE to the result register; the divide path goes
// through ST_MUL and ST_DIV, one quotient bit per cycle in the divider.
// src_stall is high from the transfer until the result is loaded.
// Reset: enable = 1, max_output = 65535, last_count = 0, both channels empty.
// A stalled result holds; the next item is taken while it waits.
`default_nettype none

module vf_adc_window_converter #(
    parameter int unsigned FULL_SCALE = vfc_pkg::FULL_SCALE_DEF,
    parameter int unsigned SPAN_RATIO = vfc_pkg::SPAN_RATIO_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input items
    input  wire logic                        src_valid,
    output logic                             src_stall,
    input  wire vfc_pkg::vfc_in_t            src_data,
    // results
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output vfc_pkg::vfc_out_t                res_data,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vfc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import vfc_pkg::*;

    // numerator (diff - win) * FULL_SCALE, denominator win * SPAN_RATIO
    localparam int unsigned NUM_W = COUNT_W + $clog2(FULL_SCALE + 1);
    localparam int unsigned DEN_W = COUNT_W + $clog2(SPAN_RATIO + 1);
    localparam int unsigned CMP_W = (NUM_W > VALUE_W) ? NUM_W : VALUE_W;
    localparam logic [NUM_W-1:0] FS_K   = NUM_W'(FULL_SCALE);
    localparam logic [DEN_W-1:0] SPAN_K = DEN_W'(SPAN_RATIO);

    vfc_cfg_t      cfg;
    vfc_div_stat_t div_stat;
    logic          div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quo;

    vfc_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] last_count_reg, last_count_next;
    logic [COUNT_W-1:0] diff_reg, diff_next;
    logic [COUNT_W-1:0] win_reg, win_next;
    logic [NUM_W-1:0]   raw_reg, raw_next;
    logic               force_sat_reg, force_sat_next;
    logic               res_valid_reg, res_valid_next;
    vfc_out_t           res_data_reg, res_data_next;

    logic               src_xfer;
    logic [COUNT_W-1:0] diff_in;
    logic               over;

    vfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vfc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .quotient    (div_quo),
        .stat        (div_stat)
    );

    assign src_stall = (state_reg != ST_IDLE);
    assign src_xfer  = src_valid && !src_stall;
    assign diff_in   = src_data.pulse_count - last_count_reg;

    // one multiply per operand, registered inside the divider on start
    assign div_num = NUM_W'(diff_reg - win_reg) * FS_K;
    assign div_den = DEN_W'(win_reg) * SPAN_K;

    assign over = force_sat_reg ||
                  (CMP_W'(raw_reg) > CMP_W'(cfg.max_output));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_count_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_count_reg <= last_count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        win_reg       <= win_next;
        raw_reg       <= raw_next;
        force_sat_reg <= force_sat_next;
        res_data_reg  <= res_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        last_count_next = last_count_reg;
        diff_next       = diff_reg;
        win_next        = win_reg;
        raw_next        = raw_reg;
        force_sat_next  = force_sat_reg;
        res_data_next   = res_data_reg;
        res_valid_next  = res_valid_reg && res_stall;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // disabled: item is dropped, last_count untouched
                if (src_xfer && cfg.enable)
                begin
                    last_count_next = src_data.pulse_count;
                    diff_next       = diff_in;
                    win_next        = src_data.window_ticks;
                    force_sat_next  = 1'b0;
                    raw_next        = '0;
                    state_next      = ST_DONE;
                    priority if (diff_in == '0)
                    begin
                        // no pulses: pin level picks full scale or zero
                        raw_next = src_data.pin_high ? FS_K : '0;
                    end
                    else if (diff_in <= src_data.window_ticks)
                    begin
                        raw_next = '0;
                    end
                    else if (src_data.window_ticks == '0)
                    begin
                        // zero-length window always clamps
                        force_sat_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    raw_next   = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next                = 1'b1;
                    res_data_next.saturated       = over;
                    res_data_next.converted_value = over ? cfg.max_output
                                                         : VALUE_W'(raw_reg);
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // waiting on the divider implies it is running
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_stat.busy)
        else $error("divide state with idle divider");

    // an enabled transfer always starts work
    a_enabled_item_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (src_xfer && cfg.enable) |=> state_reg != ST_IDLE)
        else $error("enabled item did not start");

    // a fresh result is loaded only from the final state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !$past(res_valid)) |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

@@ design/vfc_regs.sv @@
`default_nettype none

module vfc_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vfc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output vfc_pkg::vfc_cfg_t                cfg
);
    import vfc_pkg::*;

    logic               enable_reg;
    logic [VALUE_W-1:0] max_output_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= ENABLE_RST;
            max_output_reg <= MAX_OUTPUT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_MAX_OUTPUT: max_output_reg <= pwdata[VALUE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ENABLE:     prdata = {31'd0, enable_reg};
            REG_MAX_OUTPUT: prdata = {{(32-VALUE_W){1'b0}}, max_output_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.enable     = enable_reg;
    assign cfg.max_output = max_output_reg;

endmodule

`default_nettype wire

@@ design/vfc_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle through one shared
// compare/subtract.
module vfc_divider #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] denominator,
    output logic      [NUM_W-1:0] quotient,
    output vfc_pkg::vfc_div_stat_t stat
);
    import vfc_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic             done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done      = 1'b0;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = numerator;
            rem_next  = '0;
            den_next  = denominator;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                done      = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                quo_next = {quo_reg[NUM_W-2:0], fits};
                rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end
        end
    end

    assign stat.done = done;
    assign stat.busy = busy_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vfc_pkg::*;

    // Settle time after the last expected result: it outlasts the divide
    // path, so this also covers an item taken while disabled.
    localparam int unsigned SETTLE_CYCLES   = 60;
    // Slowest legal run is roughly 800 items, each with a divide, a gap and
    // a stall, plus drains and the long hold-off; this is several times that.
    localparam int unsigned TIMEOUT_CYCLES  = 400000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES   = 7;
    localparam int unsigned PHASE_ITEMS     = 100;

    // DUT connections; every input starts at a known value
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    vfc_in_t              src_data  = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    vfc_out_t             res_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Local copy of the converter state and register file
    logic                 cfg_enable  = ENABLE_RST;
    logic [VALUE_W-1:0]   cfg_ceiling = MAX_OUTPUT_RST;
    logic [COUNT_W-1:0]   prev_count  = '0;

    // Readings predicted at each input transfer, oldest first
    vfc_out_t             expected_readings [$];
    vfc_out_t             next_reading;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;

    // Idle controls for the sender and the receiver
    bit                   sender_gaps       = 1'b1;
    bit                   receiver_idles    = 1'b1;
    int unsigned          hold_off_request  = 0;

    vf_adc_window_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: pulse difference since the last window, mapped to a
    // scaled reading and clamped to the ceiling. Updates prev_count.
    // ------------------------------------------------------------------
    function automatic vfc_out_t convert_window(vfc_in_t item);
        logic [COUNT_W-1:0] diff;
        logic [63:0]        raw;
        vfc_out_t           reading;
        diff       = item.pulse_count - prev_count;
        prev_count = item.pulse_count;
        if (diff == '0)
            // no pulses at all: pin level tells stuck-high from stuck-low
            raw = item.pin_high ? 64'(FULL_SCALE_DEF) : 64'd0;
        else if (diff <= item.window_ticks)
            // at or under the baseline rate
            raw = 64'd0;
        else if (item.window_ticks == '0)
            // zero-length window: reading forced to all ones, always clamps
            raw = '1;
        else
            raw = ((64'(diff) - 64'(item.window_ticks)) * 64'(FULL_SCALE_DEF)) /
                  (64'(item.window_ticks) * 64'(SPAN_RATIO_DEF));
        if (raw > 64'(cfg_ceiling))
        begin
            reading.converted_value = cfg_ceiling;
            reading.saturated       = 1'b1;
        end
        else
        begin
            reading.converted_value = raw[VALUE_W-1:0];
            reading.saturated       = 1'b0;
        end
        return reading;
    endfunction

    function automatic void log_mismatch(string what, vfc_out_t want, vfc_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected value %0d sat %0b, got value %0d sat %0b",
                     what, want.converted_value, want.saturated,
                     got.converted_value, got.saturated);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every result transfer is matched against the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            if (expected_readings.size() == 0)
                log_mismatch("no reading pending", '0, res_data);
            else
            begin
                next_reading = expected_readings.pop_front();
                if (res_data.converted_value !== next_reading.converted_value ||
                    res_data.saturated !== next_reading.saturated)
                    log_mismatch("wrong reading", next_reading, res_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold_off_request) @(posedge clk);
                hold_off_request = 0;
                res_stall <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: one window-close item per call. Valid stays high on return
    // so back-to-back calls keep the channel busy; callers that pause
    // go through wait_for_drain, which drops valid first.
    // ------------------------------------------------------------------
    task automatic send_window(input logic [COUNT_W-1:0] count,
                               input logic [COUNT_W-1:0] window,
                               input logic pin);
        vfc_in_t item;
        item.pulse_count  = count;
        item.window_ticks = window;
        item.pin_high     = pin;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= item;
        do
            @(posedge clk);
        while (src_stall);
        // disabled converter swallows the item and keeps its state
        if (cfg_enable)
            expected_readings.push_back(convert_window(item));
    endtask

    task automatic wait_for_drain();
        src_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup phase, then access phase until pready
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENABLE)
            cfg_enable = value[0];
        else
            cfg_ceiling = value[VALUE_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: enabled, ceiling 65535, last count 0
    task automatic check_special_cases();
        send_window(16'd0, 16'd5, 1'b1);          // no pulses, pin high: full scale
        send_window(16'd0, 16'd5, 1'b0);          // no pulses, pin low: zero
        send_window(16'd0, 16'd0, 1'b1);          // no pulses, zero window
        send_window(16'd10, 16'd100, 1'b0);       // under baseline
        send_window(16'd110, 16'd100, 1'b1);      // exactly at baseline
        send_window(16'd260, 16'd100, 1'b0);      // regular divide
        send_window(16'hFFFF, 16'd1, 1'b0);       // huge ratio, clamps
        send_window(16'h0005, 16'd0, 1'b0);       // counter wrap, zero window
        send_window(16'h0004, 16'hFFFF, 1'b1);    // max difference, max window
        send_window(16'h8004, 16'h7FFF, 1'b0);    // barely above baseline
        send_window(16'h8006, 16'd1, 1'b1);       // smallest window
        wait_for_drain();
    endtask

    task automatic check_ceiling();
        write_register(REG_MAX_OUTPUT, 32'd0);
        send_window(prev_count, 16'd7, 1'b1);     // full scale clamps to zero
        send_window(prev_count + 16'd3, 16'd9, 1'b0);
        wait_for_drain();
        // upper bits beyond the register width are dropped
        write_register(REG_MAX_OUTPUT, 32'hFFFF_FFFF);
        send_window(prev_count + 16'hFFFF, 16'd1, 1'b0);   // largest raw reading
        send_window(prev_count + 16'd17, 16'd0, 1'b1);
        send_window(prev_count, 16'd1, 1'b1);
        wait_for_drain();
        // ceiling right at and just under a reading of 4095
        write_register(REG_MAX_OUTPUT, 32'd4095);
        send_window(prev_count + 16'd150, 16'd100, 1'b0);
        wait_for_drain();
        write_register(REG_MAX_OUTPUT, 32'd4094);
        send_window(prev_count + 16'd150, 16'd100, 1'b0);
        wait_for_drain();
        write_register(REG_MAX_OUTPUT, 32'(MAX_OUTPUT_RST));
    endtask

    task automatic check_disable();
        write_register(REG_ENABLE, 32'd0);
        repeat (6)
            send_window(16'($urandom), 16'($urandom), 1'($urandom));
        wait_for_drain();
        write_register(REG_ENABLE, 32'd1);
        // no pulses since the last enabled window if the count was kept
        send_window(prev_count, 16'd50, 1'b1);
        send_window(prev_count + 16'd400, 16'd50, 1'b0);
        wait_for_drain();
    endtask

    // Receiver holds off while the sender streams with no gaps
    task automatic check_backpressure();
        sender_gaps      = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < 25; i++)
            send_window(prev_count + 16'(200 + 7 * i), 16'(100 + i), 1'(i));
        wait_for_drain();
        sender_gaps = 1'b1;
    endtask

    // Phases with different ceilings and idle patterns. Most items are
    // built from the predicted last count so that the difference lands
    // above the baseline and the divide path gets exercised.
    task automatic check_random_traffic();
        logic [VALUE_W-1:0] ceiling;
        logic [COUNT_W-1:0] count;
        int unsigned        win;
        int unsigned        mode;
        logic               pin;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_drain();
            case (phase)
                0:       ceiling = MAX_OUTPUT_RST;
                1:       ceiling = VALUE_W'($urandom);
                2:       ceiling = VALUE_W'($urandom_range(0, 5000));
                3:       ceiling = '1;
                4:       ceiling = VALUE_W'($urandom_range(60000, 70000));
                5:       ceiling = VALUE_W'($urandom_range(0, 1 << 20));
                default: ceiling = MAX_OUTPUT_RST;
            endcase
            write_register(REG_MAX_OUTPUT, 32'(ceiling));
            // phase 2 and the last phase run without idling
            sender_gaps    = (phase != 2 && phase != RANDOM_PHASES - 1);
            receiver_idles = sender_gaps;
            if (phase == 4)
            begin
                write_register(REG_ENABLE, 32'd0);
                repeat (15)
                    send_window(16'($urandom), 16'($urandom), 1'($urandom));
                wait_for_drain();
                write_register(REG_ENABLE, 32'd1);
            end
            repeat (PHASE_ITEMS)
            begin
                mode = $urandom_range(0, 15);
                pin  = 1'($urandom_range(0, 1));
                case (mode)
                    0, 1:
                    begin
                        count = 16'($urandom);
                        win   = $urandom_range(0, 65535);
                    end
                    2:
                    begin
                        count = prev_count;
                        win   = $urandom_range(0, 65535);
                    end
                    3:
                    begin
                        count = 16'($urandom);
                        win   = 0;
                    end
                    4:
                    begin
                        win   = $urandom_range(1, 65535);
                        count = prev_count + 16'($urandom_range(1, win));
                    end
                    default:
                    begin
                        win   = $urandom_range(1, 1 << $urandom_range(0, 15));
                        count = prev_count + 16'(win + $urandom_range(1, 65535 - win));
                    end
                endcase
                send_window(count, 16'(win), pin);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_special_cases();
        check_ceiling();
        check_disable();
        check_backpressure();
        check_random_traffic();
        wait_for_drain();
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
